@@ rtl/core/hlsc_pkg.sv @@
package hlsc_pkg;

    // Defaults for the top-level parameters
    localparam int FULL_CIRCLE_DEF = 36000;
    localparam int GAIN_SHIFT_DEF  = 12;

    // Field widths
    localparam int HDG_W   = 16;
    localparam int VAL_W   = 16;
    localparam int LIM_W   = 15;
    localparam int AGE_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 3;

    typedef enum logic [1:0] {
        MODE_CMD  = 2'd0,
        MODE_TICK = 2'd1,
        MODE_STOP = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_MOVE = 2'd1,
        ACT_STOP = 2'd2
    } t_action;

    typedef enum logic [CIDX_W-1:0] {
        REG_HEADING_GAIN  = 3'd0,
        REG_LATERAL_GAIN  = 3'd1,
        REG_MAX_VELOCITY  = 3'd2,
        REG_MAX_STEERING  = 3'd3,
        REG_TIMEOUT_TICKS = 3'd4
    } t_reg_index;

endpackage

@@ rtl/core/heading_lateral_steering_control.sv @@
// Heading and lateral steering controller.
// Input channel (i_in_valid / o_in_ready) carries one beat per item: a new
// command (latches target heading, lateral error and clamped speed, restarts
// the command age), a control tick (ages the command and either issues a
// motion set-point or, when stale, a timeout stop) or a stop request.
// Output channel (o_out_valid / i_out_ready) returns exactly one result beat
// per input beat, in order.
// An item passes the input register and then the result register: ahead of
// the input register the incoming heading is reduced modulo a full circle (a
// constant compare-and-subtract chain, a single step for a 36000 circle);
// after it the wrapped heading error, the two gain products, the sum and the
// steering clamp are formed and the state is updated.
// Throughput is one item per cycle while the receiver takes results.
// When the receiver stalls, the result register holds and one further item
// is still taken into the input register before o_in_ready drops.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data with
// no wait; write it only while the block is idle.
// Reset (synchronous, active low) clears configuration, targets, command age,
// last error and rate and both pipeline valids; no clearing pass is needed.
module heading_lateral_steering_control_core #(
    parameter int FULL_CIRCLE = hlsc_pkg::FULL_CIRCLE_DEF,
    parameter int GAIN_SHIFT  = hlsc_pkg::GAIN_SHIFT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [hlsc_pkg::CIDX_W-1:0]         i_cfg_index,
    input  logic [hlsc_pkg::CFG_W-1:0]          i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_mode,
    input  logic [hlsc_pkg::HDG_W-1:0]          i_desired_heading,
    input  logic signed [hlsc_pkg::VAL_W-1:0]   i_lateral_offset,
    input  logic signed [hlsc_pkg::VAL_W-1:0]   i_forward_speed,
    input  logic [hlsc_pkg::HDG_W-1:0]          i_measured_heading,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_drive_action,
    output logic signed [hlsc_pkg::VAL_W-1:0]   o_linear_velocity,
    output logic signed [hlsc_pkg::VAL_W-1:0]   o_angular_rate,
    output logic signed [hlsc_pkg::VAL_W-1:0]   o_heading_error,
    output logic                                o_timed_out
);

    localparam int HW = hlsc_pkg::HDG_W;
    localparam int VW = hlsc_pkg::VAL_W;
    localparam int LW = hlsc_pkg::LIM_W;
    localparam int AW = hlsc_pkg::AGE_W;

    // quotient bits needed to reduce any 16-bit heading by a full circle
    localparam int QBITS = $clog2(((1 << HW) - 1) / FULL_CIRCLE + 1);

    localparam logic [31:0]        FC_U   = 32'(FULL_CIRCLE);
    localparam logic signed [17:0] FC_S   = 18'(FULL_CIRCLE);
    localparam logic signed [17:0] HALF_S = 18'(FULL_CIRCLE / 2);
    localparam logic signed [17:0] UPR_S  = 18'(FULL_CIRCLE - FULL_CIRCLE / 2);

    function automatic logic [HW-1:0] f_circle_mod(input logic [HW-1:0] v);
        logic [31:0] rem;
        rem = 32'(v);
        for (int k = QBITS - 1; k >= 0; k--) begin
            if (rem >= (FC_U << k)) begin
                rem = rem - (FC_U << k);
            end
        end
        return rem[HW-1:0];
    endfunction

    // configuration registers
    logic signed [VW-1:0] r_heading_gain;
    logic signed [VW-1:0] r_lateral_gain;
    logic [LW-1:0]        r_max_velocity;
    logic [LW-1:0]        r_max_steering;
    logic [AW-1:0]        r_timeout_ticks;

    // controller state
    logic [HW-1:0]        r_target_heading, n_target_heading;
    logic [HW-1:0]        r_target_mod,     n_target_mod;
    logic signed [VW-1:0] r_target_lateral, n_target_lateral;
    logic signed [VW-1:0] r_target_speed,   n_target_speed;
    logic [AW-1:0]        r_command_age,    n_command_age;
    logic signed [VW-1:0] r_last_error,     n_last_error;
    logic signed [VW-1:0] r_last_rate,      n_last_rate;

    // input register
    logic                 r_s1_valid;
    logic [1:0]           r_s1_mode;
    logic [HW-1:0]        r_s1_hdg;
    logic [HW-1:0]        r_s1_hdg_mod;
    logic signed [VW-1:0] r_s1_lateral;
    logic signed [VW-1:0] r_s1_speed;

    // result register
    logic                 r_out_valid;
    logic [1:0]           r_action,  n_action;
    logic signed [VW-1:0] r_lin_vel;
    logic signed [VW-1:0] r_ang_rate;
    logic signed [VW-1:0] r_hdg_err;
    logic                 r_tout,    n_tout;

    logic                 w_adv;
    logic                 w_fire;
    logic                 w_accept;
    logic [HW-1:0]        w_hdg_sel;

    // ---------------------------------------------------------------- control
    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_fire     = r_s1_valid && w_adv;
    assign o_in_ready = !r_s1_valid || w_adv;
    assign w_accept   = i_in_valid && o_in_ready;

    // commands carry the desired heading, ticks the measured one
    assign w_hdg_sel = (i_mode == hlsc_pkg::MODE_CMD) ? i_desired_heading
                                                      : i_measured_heading;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_mode    <= i_mode;
            r_s1_hdg     <= w_hdg_sel;
            r_s1_hdg_mod <= f_circle_mod(w_hdg_sel);
            r_s1_lateral <= i_lateral_offset;
            r_s1_speed   <= i_forward_speed;
        end
    end

    // ---------------------------------------------------------- configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading_gain  <= '0;
            r_lateral_gain  <= '0;
            r_max_velocity  <= '0;
            r_max_steering  <= '0;
            r_timeout_ticks <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                hlsc_pkg::REG_HEADING_GAIN:  r_heading_gain  <= i_cfg_data;
                hlsc_pkg::REG_LATERAL_GAIN:  r_lateral_gain  <= i_cfg_data;
                hlsc_pkg::REG_MAX_VELOCITY:  r_max_velocity  <= i_cfg_data[LW-1:0];
                hlsc_pkg::REG_MAX_STEERING:  r_max_steering  <= i_cfg_data[LW-1:0];
                hlsc_pkg::REG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data[AW-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------ datapath
    logic signed [16:0] w_spd_lim;
    logic signed [16:0] w_spd_in;
    logic signed [VW-1:0] w_spd_clamped;

    logic [AW-1:0]      w_age_inc;
    logic               w_expired;

    logic signed [17:0] w_err_raw;
    logic signed [17:0] w_diff;
    logic signed [17:0] w_res;
    logic signed [17:0] w_wrapped;
    logic signed [VW-1:0] w_err16;

    logic signed [31:0] w_prod_h;
    logic signed [31:0] w_prod_l;
    logic signed [32:0] w_rate;
    logic signed [32:0] w_rate_lim;
    logic signed [VW-1:0] w_rate16;

    always_comb begin
        w_spd_lim = $signed({2'b00, r_max_velocity});
        w_spd_in  = 17'(r_s1_speed);
        if (w_spd_in > w_spd_lim) begin
            w_spd_clamped = w_spd_lim[VW-1:0];
        end else if (w_spd_in < -w_spd_lim) begin
            w_spd_clamped = VW'(-w_spd_lim);
        end else begin
            w_spd_clamped = r_s1_speed;
        end
    end

    assign w_age_inc = (r_command_age == {AW{1'b1}}) ? r_command_age
                                                      : r_command_age + AW'(1);
    assign w_expired = w_age_inc > r_timeout_ticks;

    // wrap the heading error into half a circle either side of zero
    always_comb begin
        w_err_raw = $signed({2'b00, r_target_heading}) - $signed({2'b00, r_s1_hdg});
        w_diff    = $signed({2'b00, r_target_mod}) - $signed({2'b00, r_s1_hdg_mod});
        w_res     = (w_diff < 0) ? w_diff + FC_S : w_diff;
        if (w_err_raw > HALF_S) begin
            w_wrapped = (w_res <= HALF_S) ? w_res : w_res - FC_S;
        end else if (w_err_raw < -HALF_S) begin
            w_wrapped = (w_res < UPR_S) ? w_res : w_res - FC_S;
        end else begin
            w_wrapped = w_err_raw;
        end
        w_err16 = w_wrapped[VW-1:0];
    end

    always_comb begin
        w_prod_h   = r_heading_gain * w_err16;
        w_prod_l   = r_lateral_gain * r_target_lateral;
        w_rate     = 33'(w_prod_h >>> GAIN_SHIFT) + 33'(w_prod_l >>> GAIN_SHIFT);
        w_rate_lim = $signed({18'd0, r_max_steering});
        if (w_rate > w_rate_lim) begin
            w_rate16 = w_rate_lim[VW-1:0];
        end else if (w_rate < -w_rate_lim) begin
            w_rate16 = VW'(-w_rate_lim);
        end else begin
            w_rate16 = w_rate[VW-1:0];
        end
    end

    // ------------------------------------------------------ state and result
    always_comb begin
        n_target_heading = r_target_heading;
        n_target_mod     = r_target_mod;
        n_target_lateral = r_target_lateral;
        n_target_speed   = r_target_speed;
        n_command_age    = r_command_age;
        n_last_error     = r_last_error;
        n_last_rate      = r_last_rate;
        n_action         = hlsc_pkg::ACT_NONE;
        n_tout           = 1'b0;
        case (r_s1_mode)
            hlsc_pkg::MODE_CMD: begin
                n_target_heading = r_s1_hdg;
                n_target_mod     = r_s1_hdg_mod;
                n_target_lateral = r_s1_lateral;
                n_target_speed   = w_spd_clamped;
                n_command_age    = '0;
            end
            hlsc_pkg::MODE_TICK: begin
                n_command_age = w_age_inc;
                if (w_expired) begin
                    // drop the stale command
                    n_target_heading = '0;
                    n_target_mod     = '0;
                    n_target_lateral = '0;
                    n_target_speed   = '0;
                    n_last_error     = '0;
                    n_last_rate      = '0;
                    n_action         = hlsc_pkg::ACT_STOP;
                    n_tout           = 1'b1;
                end else begin
                    n_last_error = w_err16;
                    n_last_rate  = w_rate16;
                    n_action     = hlsc_pkg::ACT_MOVE;
                end
            end
            hlsc_pkg::MODE_STOP: begin
                n_target_heading = '0;
                n_target_mod     = '0;
                n_target_lateral = '0;
                n_target_speed   = '0;
                n_last_error     = '0;
                n_last_rate      = '0;
                n_action         = hlsc_pkg::ACT_STOP;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_heading <= '0;
            r_target_mod     <= '0;
            r_target_lateral <= '0;
            r_target_speed   <= '0;
            r_command_age    <= '0;
            r_last_error     <= '0;
            r_last_rate      <= '0;
        end else if (w_fire) begin
            r_target_heading <= n_target_heading;
            r_target_mod     <= n_target_mod;
            r_target_lateral <= n_target_lateral;
            r_target_speed   <= n_target_speed;
            r_command_age    <= n_command_age;
            r_last_error     <= n_last_error;
            r_last_rate      <= n_last_rate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_action   <= n_action;
            r_lin_vel  <= n_target_speed;
            r_ang_rate <= n_last_rate;
            r_hdg_err  <= n_last_error;
            r_tout     <= n_tout;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_drive_action    = r_action;
    assign o_linear_velocity = r_lin_vel;
    assign o_angular_rate    = r_ang_rate;
    assign o_heading_error   = r_hdg_err;
    assign o_timed_out       = r_tout;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HALF_CIRCLE = hlsc_pkg::FULL_CIRCLE_DEF / 2;
    localparam int HOLD_CYCLES = 80;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]         mode;
        logic [15:0]        desired_heading;
        logic signed [15:0] lateral_offset;
        logic signed [15:0] forward_speed;
        logic [15:0]        measured_heading;
    } t_steer_item;

    typedef struct {
        logic [1:0]         action;
        logic signed [15:0] velocity;
        logic signed [15:0] rate;
        logic signed [15:0] error;
        logic               timed_out;
    } t_steer_result;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_we = 1'b0;
    logic [hlsc_pkg::CIDX_W-1:0]  i_cfg_index = '0;
    logic [hlsc_pkg::CFG_W-1:0]   i_cfg_data = '0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_ready;
    logic [1:0]                   i_mode = '0;
    logic [hlsc_pkg::HDG_W-1:0]   i_desired_heading = '0;
    logic signed [15:0]           i_lateral_offset = '0;
    logic signed [15:0]           i_forward_speed = '0;
    logic [hlsc_pkg::HDG_W-1:0]   i_measured_heading = '0;
    logic                         o_out_valid;
    logic                         i_out_ready = 1'b0;
    logic [1:0]                   o_drive_action;
    logic signed [15:0]           o_linear_velocity;
    logic signed [15:0]           o_angular_rate;
    logic signed [15:0]           o_heading_error;
    logic                         o_timed_out;

    heading_lateral_steering_control_core u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_mode             (i_mode),
        .i_desired_heading  (i_desired_heading),
        .i_lateral_offset   (i_lateral_offset),
        .i_forward_speed    (i_forward_speed),
        .i_measured_heading (i_measured_heading),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_drive_action     (o_drive_action),
        .o_linear_velocity  (o_linear_velocity),
        .o_angular_rate     (o_angular_rate),
        .o_heading_error    (o_heading_error),
        .o_timed_out        (o_timed_out)
    );

    // controller copy: settings and state
    logic signed [15:0] k_heading = '0;
    logic signed [15:0] k_lateral = '0;
    logic [14:0]        vel_limit = '0;
    logic [14:0]        steer_limit = '0;
    logic [15:0]        timeout_limit = '0;
    logic [15:0]        tgt_heading = '0;
    logic signed [15:0] tgt_lateral = '0;
    logic signed [15:0] tgt_speed = '0;
    logic [15:0]        cmd_age = '0;
    logic signed [15:0] last_err = '0;
    logic signed [15:0] last_rate = '0;

    t_steer_result steer_q[$];
    t_steer_result want;

    int mismatches = 0;
    int results_seen = 0;
    int cycles = 0;
    int n_commands = 0;
    int n_ticks = 0;
    int n_timeouts = 0;
    int n_stops = 0;
    int n_unused = 0;
    int n_settings = 0;
    int stall_pct = 0;
    int hold_off = 0;
    int hold_req = 0;
    int hold_done = 0;
    int burst_left = 0;

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: run stalled, %0d results still outstanding",
                     $time, steer_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: long hold-offs on request, otherwise random stalls
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            i_out_ready <= 1'b0;
            hold_off <= hold_off - 1;
        end else if (hold_done != hold_req) begin
            i_out_ready <= 1'b0;
            hold_off <= HOLD_CYCLES - 1;
            hold_done <= hold_done + 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic void clear_targets();
        tgt_heading = '0;
        tgt_lateral = '0;
        tgt_speed   = '0;
        last_err    = '0;
        last_rate   = '0;
    endfunction

    function automatic t_steer_result predict_steering(input t_steer_item it);
        t_steer_result      r;
        int                 err;
        int                 speed;
        longint             rate;
        logic signed [15:0] err16;
        r.action    = hlsc_pkg::ACT_NONE;
        r.timed_out = 1'b0;
        case (it.mode)
            hlsc_pkg::MODE_CMD: begin
                tgt_heading = it.desired_heading;
                tgt_lateral = it.lateral_offset;
                speed = it.forward_speed;
                if (speed > int'(vel_limit))
                    speed = int'(vel_limit);
                else if (speed < -int'(vel_limit))
                    speed = -int'(vel_limit);
                tgt_speed = 16'(speed);
                cmd_age = '0;
                n_commands++;
            end
            hlsc_pkg::MODE_TICK: begin
                n_ticks++;
                if (cmd_age != 16'hFFFF)
                    cmd_age = cmd_age + 16'd1;
                if (cmd_age > timeout_limit) begin
                    // stale command: drop it, keep the age
                    clear_targets();
                    r.action    = hlsc_pkg::ACT_STOP;
                    r.timed_out = 1'b1;
                    n_timeouts++;
                end else begin
                    err = int'(tgt_heading) - int'(it.measured_heading);
                    while (err > HALF_CIRCLE)
                        err -= hlsc_pkg::FULL_CIRCLE_DEF;
                    while (err < -HALF_CIRCLE)
                        err += hlsc_pkg::FULL_CIRCLE_DEF;
                    err16 = 16'(err);
                    rate = ((longint'(k_heading) * longint'(err16))
                            >>> hlsc_pkg::GAIN_SHIFT_DEF)
                         + ((longint'(k_lateral) * longint'(tgt_lateral))
                            >>> hlsc_pkg::GAIN_SHIFT_DEF);
                    if (rate > longint'(steer_limit))
                        rate = longint'(steer_limit);
                    else if (rate < -longint'(steer_limit))
                        rate = -longint'(steer_limit);
                    last_err  = err16;
                    last_rate = 16'(rate);
                    r.action  = hlsc_pkg::ACT_MOVE;
                end
            end
            hlsc_pkg::MODE_STOP: begin
                clear_targets();
                r.action = hlsc_pkg::ACT_STOP;
                n_stops++;
            end
            default: n_unused++;
        endcase
        r.velocity = tgt_speed;
        r.rate     = last_rate;
        r.error    = last_err;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] exp_val,
                                        input logic [15:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, $signed(exp_val), $signed(act_val));
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (steer_q.size() == 0) begin
                $display("%0t: result with nothing outstanding, action %0d",
                         $time, o_drive_action);
                mismatches++;
            end else begin
                want = steer_q.pop_front();
                check_field("drive_action", 16'(want.action), 16'(o_drive_action));
                check_field("linear_velocity", want.velocity, o_linear_velocity);
                check_field("angular_rate", want.rate, o_angular_rate);
                check_field("heading_error", want.error, o_heading_error);
                check_field("timed_out", 16'(want.timed_out), 16'(o_timed_out));
                results_seen++;
            end
        end
    end

    function automatic t_steer_item make_item(input logic [1:0] mode, input logic [15:0] dh,
                                              input logic [15:0] lat, input logic [15:0] spd,
                                              input logic [15:0] mh);
        t_steer_item it;
        it.mode             = mode;
        it.desired_heading  = dh;
        it.lateral_offset   = lat;
        it.forward_speed    = spd;
        it.measured_heading = mh;
        return it;
    endfunction

    function automatic logic [15:0] pick_heading();
        case ($urandom_range(9))
            0: return 16'($urandom);
            1: return 16'd0;
            2: return 16'd35999;
            default: return 16'($urandom_range(35999));
        endcase
    endfunction

    function automatic logic [15:0] pick_signed();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_item(input t_steer_item it);
        @(negedge i_clk);
        i_in_valid         <= 1'b1;
        i_mode             <= it.mode;
        i_desired_heading  <= it.desired_heading;
        i_lateral_offset   <= it.lateral_offset;
        i_forward_speed    <= it.forward_speed;
        i_measured_heading <= it.measured_heading;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        steer_q.push_back(predict_steering(it));
    endtask

    // send in bursts with random gaps between them
    task automatic offer(input t_steer_item it);
        if (burst_left == 0) begin
            repeat ($urandom_range(6, 1)) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
            burst_left = (stall_pct == 0) ? $urandom_range(60, 20) : $urandom_range(24, 1);
        end
        burst_left--;
        send_item(it);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (steer_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input hlsc_pkg::t_reg_index idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            hlsc_pkg::REG_HEADING_GAIN:  k_heading = val;
            hlsc_pkg::REG_LATERAL_GAIN:  k_lateral = val;
            hlsc_pkg::REG_MAX_VELOCITY:  vel_limit = val[14:0];
            hlsc_pkg::REG_MAX_STEERING:  steer_limit = val[14:0];
            hlsc_pkg::REG_TIMEOUT_TICKS: timeout_limit = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [15:0] hg, input logic [15:0] lg,
                                  input logic [15:0] mv, input logic [15:0] ms,
                                  input logic [15:0] tmo);
        drain();
        write_reg(hlsc_pkg::REG_HEADING_GAIN, hg);
        write_reg(hlsc_pkg::REG_LATERAL_GAIN, lg);
        write_reg(hlsc_pkg::REG_MAX_VELOCITY, mv);
        write_reg(hlsc_pkg::REG_MAX_STEERING, ms);
        write_reg(hlsc_pkg::REG_TIMEOUT_TICKS, tmo);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic test_reset_defaults();
        // zero timeout after reset: the first tick times out
        send_item(make_item(hlsc_pkg::MODE_TICK, 16'd100, 16'd5, 16'd5, 16'd200));
    endtask

    task automatic test_wrap_and_limits();
        apply_settings(16'd2000, -16'sd1500, 16'd1000, 16'd20000, 16'd5);
        send_item(make_item(hlsc_pkg::MODE_CMD, 16'd0, 16'h7FFF, 16'h7FFF, 16'd0));
        send_item(make_item(hlsc_pkg::MODE_TICK, 16'd0, 16'd0, 16'd0, 16'd35999));
        send_item(make_item(hlsc_pkg::MODE_TICK, 16'hFFFF, 16'h8000, 16'h8000, 16'd0));
        send_item(make_item(hlsc_pkg::MODE_TICK, 16'd0, 16'd0, 16'd0, 16'd18000));
        send_item(make_item(hlsc_pkg::MODE_CMD, 16'd35999, 16'h8000, 16'h8000, 16'd0));
        send_item(make_item(hlsc_pkg::MODE_TICK, 16'd0, 16'd0, 16'd0, 16'd17999));
        // heading beyond a full circle
        send_item(make_item(hlsc_pkg::MODE_TICK, 16'd0, 16'd0, 16'd0, 16'hFFFF));
        send_item(make_item(hlsc_pkg::MODE_CMD, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF));
        send_item(make_item(hlsc_pkg::MODE_TICK, 16'd0, 16'd0, 16'd0, 16'd0));
        send_item(make_item(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(make_item(hlsc_pkg::MODE_STOP, 16'd1234, 16'd99, 16'd99, 16'd4321));
        send_item(make_item(hlsc_pkg::MODE_TICK, 16'd0, 16'd0, 16'd0, 16'd9000));
    endtask

    task automatic test_steering_clamp();
        apply_settings(16'h7FFF, 16'h8000, 16'h7FFF, 16'd100, 16'd100);
        send_item(make_item(hlsc_pkg::MODE_CMD, 16'd18000, 16'h7FFF, 16'h7FFF, 16'd0));
        send_item(make_item(hlsc_pkg::MODE_TICK, 16'd0, 16'd0, 16'd0, 16'd0));
        send_item(make_item(hlsc_pkg::MODE_CMD, 16'd18000, 16'h8000, 16'h8000, 16'd0));
        send_item(make_item(hlsc_pkg::MODE_TICK, 16'd0, 16'd0, 16'd0, 16'd18000));
    endtask

    task automatic test_timeout();
        apply_settings(16'd3000, 16'd700, 16'd500, 16'd5000, 16'd2);
        send_item(make_item(hlsc_pkg::MODE_CMD, 16'd9000, 16'd400, 16'd300, 16'd0));
        repeat (4)
            send_item(make_item(hlsc_pkg::MODE_TICK, 16'd0, 16'd0, 16'd0, 16'd8000));
        // a fresh command restarts the age
        send_item(make_item(hlsc_pkg::MODE_CMD, 16'd27000, -16'sd400, -16'sd900, 16'd0));
        send_item(make_item(hlsc_pkg::MODE_TICK, 16'd0, 16'd0, 16'd0, 16'd100));
    endtask

    task automatic test_backpressure();
        drain();
        stall_pct = 0;
        hold_req  = hold_req + 1;
        repeat (30)
            send_item(make_item($urandom_range(1) ? hlsc_pkg::MODE_TICK
                                                  : hlsc_pkg::MODE_CMD,
                                pick_heading(), pick_signed(), pick_signed(),
                                pick_heading()));
        drain();
    endtask

    task automatic run_phase(input int n_items);
        int          sent;
        int          run_len;
        int          span;
        t_steer_item it;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 85) begin
                // command followed by a run of ticks, sometimes past the timeout
                offer(make_item(hlsc_pkg::MODE_CMD, pick_heading(), pick_signed(),
                                pick_signed(), pick_heading()));
                span = (timeout_limit < 16'd10) ? int'(timeout_limit) + 3 : 12;
                run_len = $urandom_range(span);
                repeat (run_len)
                    offer(make_item(hlsc_pkg::MODE_TICK, pick_heading(), pick_signed(),
                                    pick_signed(), pick_heading()));
                sent += 1 + run_len;
                if ($urandom_range(4) == 0) begin
                    offer(make_item(hlsc_pkg::MODE_STOP, pick_heading(), pick_signed(),
                                    pick_signed(), pick_heading()));
                    sent++;
                end
            end else begin
                it = make_item(2'($urandom_range(3)), pick_heading(), pick_signed(),
                               pick_signed(), pick_heading());
                offer(it);
                if (it.mode != MODE_UNUSED)
                    sent++;
            end
        end
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: apply_settings(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                1: apply_settings(16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
                default: apply_settings(16'($urandom), 16'($urandom), 16'($urandom),
                                        16'($urandom), 16'($urandom_range(12)));
            endcase
            stall_pct = (p % 4) * 25;
            run_phase(150);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_wrap_and_limits();
        test_steering_clamp();
        test_timeout();
        test_backpressure();
        test_random_phases();

        drain();
        repeat (10) @(posedge i_clk);
        if (steer_q.size() != 0)
            $display("%0t: %0d results never arrived", $time, steer_q.size());
        $display("Covered %0d commands, %0d ticks (%0d timed out), %0d stops, %0d unused-mode",
                 n_commands, n_ticks, n_timeouts, n_stops, n_unused);
        $display("over %0d register settings; %0d results checked, %0d mismatches",
                 n_settings, results_seen, mismatches);
        if (mismatches == 0 && steer_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
